// ----- hdl/tllm_pkg.sv -----
package tllm_pkg;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_W    = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;
   localparam int REQ_PAD_W  = REQ_DATA_W - OP_W - 2 * KEY_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - 2 * KEY_W - ENTRY_W;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_POP    = 2'd2,
      OP_PEEK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE = 2'd0,
      STAT_FULL = 2'd1,
      STAT_MISS = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_APPEND_TAIL,
      ST_APPEND,
      ST_LINK_RD,
      ST_UNLINK,
      ST_PEEK_RD,
      ST_RESULT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic clear_step;
      logic scan_start;
      logic scan_step;
      logic set_full;
      logic set_miss;
      logic target_head;
      logic append_tail;
      logic append;
      logic link_rd;
      logic unlink;
      logic peek_rd;
      logic rsp_peek;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   count_zero;
      logic   count_full;
      logic   scan_hit;
      logic   scan_end;
      logic   clear_last;
      logic   rsp_busy;
   } stat_type;

endpackage

// ----- hdl/tllm_ctrl.sv -----
module tllm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tllm_pkg::stat_type stat,
   output tllm_pkg::cmd_type  cmd
);

   tllm_pkg::state_type state_ff;
   tllm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tllm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tllm_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = tllm_pkg::ST_IDLE;
         end
         tllm_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tllm_pkg::ST_DECODE;
         end
         tllm_pkg::ST_DECODE: begin
            case (stat.op)
               tllm_pkg::OP_APPEND: begin
                  state_in = stat.count_full ? tllm_pkg::ST_RESULT : tllm_pkg::ST_SCAN;
               end
               tllm_pkg::OP_REMOVE: state_in = tllm_pkg::ST_SCAN;
               tllm_pkg::OP_POP: begin
                  state_in = stat.count_zero ? tllm_pkg::ST_RESULT : tllm_pkg::ST_LINK_RD;
               end
               tllm_pkg::OP_PEEK: begin
                  state_in = stat.count_zero ? tllm_pkg::ST_RESULT : tllm_pkg::ST_PEEK_RD;
               end
               default: state_in = tllm_pkg::ST_RESULT;
            endcase
         end
         tllm_pkg::ST_SCAN: begin
            if (stat.scan_hit) begin
               if (stat.op == tllm_pkg::OP_APPEND) begin
                  state_in = stat.count_zero ? tllm_pkg::ST_APPEND : tllm_pkg::ST_APPEND_TAIL;
               end else begin
                  state_in = tllm_pkg::ST_LINK_RD;
               end
            end else if (stat.scan_end) begin
               state_in = tllm_pkg::ST_RESULT;
            end
         end
         tllm_pkg::ST_APPEND_TAIL: state_in = tllm_pkg::ST_APPEND;
         tllm_pkg::ST_APPEND:      state_in = tllm_pkg::ST_RESULT;
         tllm_pkg::ST_LINK_RD:     state_in = tllm_pkg::ST_UNLINK;
         tllm_pkg::ST_UNLINK:      state_in = tllm_pkg::ST_RESULT;
         tllm_pkg::ST_PEEK_RD:     state_in = tllm_pkg::ST_RESULT;
         tllm_pkg::ST_RESULT: begin
            if (!stat.rsp_busy) state_in = tllm_pkg::ST_IDLE;
         end
         default: state_in = tllm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tllm_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         tllm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         tllm_pkg::ST_DECODE: begin
            case (stat.op)
               tllm_pkg::OP_APPEND: begin
                  cmd.set_full   = stat.count_full;
                  cmd.scan_start = !stat.count_full;
               end
               tllm_pkg::OP_REMOVE: cmd.scan_start = 1'b1;
               tllm_pkg::OP_POP: begin
                  cmd.set_miss    = stat.count_zero;
                  cmd.target_head = 1'b1;
               end
               tllm_pkg::OP_PEEK: cmd.set_miss = stat.count_zero;
               default: cmd.set_miss = 1'b1;
            endcase
         end
         tllm_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.set_miss  = stat.scan_end && !stat.scan_hit;
         end
         tllm_pkg::ST_APPEND_TAIL: cmd.append_tail = 1'b1;
         tllm_pkg::ST_APPEND:      cmd.append      = 1'b1;
         tllm_pkg::ST_LINK_RD:     cmd.link_rd     = 1'b1;
         tllm_pkg::ST_UNLINK:      cmd.unlink      = 1'b1;
         tllm_pkg::ST_PEEK_RD:     cmd.peek_rd     = 1'b1;
         tllm_pkg::ST_RESULT: begin
            cmd.load_rsp = !stat.rsp_busy;
            cmd.rsp_peek = (stat.op == tllm_pkg::OP_PEEK) && !stat.count_zero;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- hdl/tllm_dp.sv -----
module tllm_dp #(
   parameter int CAPACITY = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tllm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tllm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  tllm_pkg::cmd_type                   cmd,
   output tllm_pkg::stat_type                  stat
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XYW = 2 * tllm_pkg::KEY_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

   // slot tables
   logic           used_mem [CAPACITY];
   logic [XYW-1:0] xy_mem   [CAPACITY];
   logic [IW-1:0]  next_mem [CAPACITY];
   logic [IW-1:0]  prev_mem [CAPACITY];

   logic           used_rd_ff;
   logic [XYW-1:0] xy_rd_ff;
   logic [IW-1:0]  next_rd_ff;
   logic [IW-1:0]  prev_rd_ff;

   tllm_pkg::op_type     op_ff;
   logic [XYW-1:0]       key_ff;
   logic [CW-1:0]        count_ff,  count_in;
   logic [IW-1:0]        head_ff,   head_in;
   logic [IW-1:0]        tail_ff,   tail_in;
   logic [IW-1:0]        target_ff, target_in;
   logic [IW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 scan_more_ff, scan_more_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IW-1:0]        chk_idx_ff,   chk_idx_in;
   tllm_pkg::status_type status_ff,    status_in;
   logic                 rsp_valid_ff;
   logic [tllm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic           match;
   logic           scan_hit;
   logic           is_head;
   logic           is_tail;
   logic           last_one;
   logic           used_we, used_wd;
   logic [IW-1:0]  used_wa;
   logic           next_we, prev_we;
   logic [IW-1:0]  next_wa, next_wd, prev_wa, prev_wd;
   logic           xy_re;
   logic [IW-1:0]  xy_ra;
   logic [tllm_pkg::KEY_W-1:0] rsp_x, rsp_y;

   assign match = (op_ff == tllm_pkg::OP_APPEND) ? !used_rd_ff
                                                 : (used_rd_ff && (xy_rd_ff == key_ff));
   assign scan_hit = chk_valid_ff && match;
   assign is_head  = (target_ff == head_ff);
   assign is_tail  = (target_ff == tail_ff);
   assign last_one = (count_ff == CW'(1));

   assign stat.op         = op_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff == FULL_CNT);
   assign stat.scan_hit   = scan_hit;
   assign stat.scan_end   = chk_valid_ff && (chk_idx_ff == LAST_IDX);
   assign stat.clear_last = (scan_addr_ff == LAST_IDX);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   // memory port selection
   always_comb begin
      used_we = 1'b0;
      used_wa = target_ff;
      used_wd = 1'b0;
      next_we = 1'b0;
      next_wa = target_ff;
      next_wd = target_ff;
      prev_we = 1'b0;
      prev_wa = target_ff;
      prev_wd = target_ff;
      if (cmd.clear_step) begin
         used_we = 1'b1;
         used_wa = scan_addr_ff;
      end
      if (cmd.append_tail) begin
         next_we = 1'b1;
         next_wa = tail_ff;
      end
      if (cmd.append) begin
         used_we = 1'b1;
         used_wd = 1'b1;
         next_we = 1'b1;
         prev_we = 1'b1;
         prev_wd = (count_ff == '0) ? target_ff : tail_ff;
      end
      if (cmd.unlink) begin
         used_we = 1'b1;
         next_we = !last_one && !is_head;
         next_wa = prev_rd_ff;
         next_wd = next_rd_ff;
         prev_we = !last_one && !is_tail;
         prev_wa = next_rd_ff;
         prev_wd = prev_rd_ff;
      end
   end

   assign xy_re = (cmd.scan_step && scan_more_ff) || cmd.peek_rd;
   assign xy_ra = cmd.peek_rd ? head_ff : scan_addr_ff;

   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_wa] <= used_wd;
      if (cmd.append) xy_mem[target_ff] <= key_ff;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (xy_re) begin
         used_rd_ff <= used_mem[xy_ra];
         xy_rd_ff   <= xy_mem[xy_ra];
      end
      if (cmd.link_rd) begin
         next_rd_ff <= next_mem[target_ff];
         prev_rd_ff <= prev_mem[target_ff];
      end
   end

   // control registers and list pointers
   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      target_in    = target_ff;
      scan_addr_in = scan_addr_ff;
      scan_more_in = scan_more_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      status_in    = status_ff;
      if (cmd.load) status_in = tllm_pkg::STAT_DONE;
      if (cmd.set_full) status_in = tllm_pkg::STAT_FULL;
      if (cmd.set_miss) status_in = tllm_pkg::STAT_MISS;
      if (cmd.clear_step) begin
         scan_addr_in = (scan_addr_ff == LAST_IDX) ? '0 : scan_addr_ff + IW'(1);
      end
      if (cmd.scan_start) begin
         scan_addr_in = '0;
         scan_more_in = 1'b1;
      end
      if (cmd.scan_step) begin
         if (scan_more_ff) begin
            chk_valid_in = 1'b1;
            chk_idx_in   = scan_addr_ff;
            if (scan_addr_ff == LAST_IDX) begin
               scan_more_in = 1'b0;
            end else begin
               scan_addr_in = scan_addr_ff + IW'(1);
            end
         end
         // freeze the scan once a slot qualifies
         if (scan_hit) begin
            target_in    = chk_idx_ff;
            scan_more_in = 1'b0;
            chk_valid_in = 1'b0;
         end
      end
      if (cmd.target_head) target_in = head_ff;
      if (cmd.append) begin
         if (count_ff == '0) head_in = target_ff;
         tail_in  = target_ff;
         count_in = count_ff + CW'(1);
      end
      if (cmd.unlink) begin
         count_in = count_ff - CW'(1);
         if (last_one) begin
            head_in = '0;
            tail_in = '0;
         end else begin
            if (is_head) head_in = next_rd_ff;
            if (is_tail) tail_in = prev_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         scan_addr_ff <= '0;
         scan_more_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         scan_addr_ff <= scan_addr_in;
         scan_more_ff <= scan_more_in;
         chk_valid_ff <= chk_valid_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_x = cmd.rsp_peek ? xy_rd_ff[XYW-1:tllm_pkg::KEY_W] : '0;
   assign rsp_y = cmd.rsp_peek ? xy_rd_ff[tllm_pkg::KEY_W-1:0]   : '0;

   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      if (cmd.load) begin
         op_ff  <= tllm_pkg::op_type'(req_tdata[tllm_pkg::OP_W-1:0]);
         key_ff <= {req_tdata[tllm_pkg::OP_W +: tllm_pkg::KEY_W],
                    req_tdata[tllm_pkg::OP_W + tllm_pkg::KEY_W +: tllm_pkg::KEY_W]};
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {{tllm_pkg::RSP_PAD_W{1'b0}},
                         tllm_pkg::ENTRY_W'(count_ff), rsp_y, rsp_x, status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above capacity");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with nonzero head or tail");

   a_unlink_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.unlink |-> (count_ff != '0))
      else $error("unlink on empty list");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not advance count");
`endif

endmodule

// ----- hdl/table_linked_list_manager.sv -----
// Sequencing: append and remove scan the slot table from accept to result
//   (slot scan reads one slot a cycle); pop, peek and a full append need no scan.
// One word is in flight at a time; the next word is taken only once the result
//   of the last one is registered.
// Reset: synchronous, active high; after reset the occupancy table is swept
//   slot by slot before the first request word is accepted.
module table_linked_list_manager #(
   parameter int CAPACITY = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: [1:0] opcode, [33:2] key_x, [65:34] key_y, [71:66] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tllm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response: [1:0] status, [33:2] head_x, [65:34] head_y,
   //           [73:66] entry_count, [79:74] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tllm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // Command and status between sequencer and slot datapath. The sequencer
   // walks decode, scan, relink and result steps; the datapath owns the slot
   // tables, head/tail/count and the response register, which frees the
   // sequencer to return to idle while a result waits on rsp_tready.
   tllm_pkg::cmd_type  cmd;
   tllm_pkg::stat_type stat;

   tllm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tllm_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ----- tb/tb_table_linked_list_manager.sv -----
module tb_table_linked_list_manager;

   localparam int CAPACITY   = 128;
   localparam int RANDOM_WORDS = 950;
   localparam int SCRIPT_LEN = 25;

   localparam logic [tllm_pkg::KEY_W-1:0] MIN_KEY  = 32'h8000_0000;
   localparam logic [tllm_pkg::KEY_W-1:0] MAX_KEY  = 32'h7fff_ffff;
   localparam logic [tllm_pkg::KEY_W-1:0] ONES_KEY = 32'hffff_ffff;

   // one reply word, field by field
   typedef struct packed {
      tllm_pkg::status_type                status;
      logic [tllm_pkg::KEY_W-1:0]          head_x;
      logic [tllm_pkg::KEY_W-1:0]          head_y;
      logic [tllm_pkg::ENTRY_W-1:0]        entry_count;
   } list_reply_type;

   localparam list_reply_type NO_REPLY = '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd0};

   // one line of the directed script; typed replies are used only where fixed is set
   typedef struct {
      tllm_pkg::op_type           op;
      logic [tllm_pkg::KEY_W-1:0] kx;
      logic [tllm_pkg::KEY_W-1:0] ky;
      bit                         fixed;
      list_reply_type             reply;
   } script_row_type;

   // operation mix of one random stretch
   typedef enum int {
      MIX_GROW,
      MIX_EVEN,
      MIX_SHRINK
   } mix_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tllm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tllm_pkg::RSP_DATA_W-1:0] rsp_tdata;

   table_linked_list_manager #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the slot table and list pointers
   // ---------------------------------------------------------------------
   logic [tllm_pkg::KEY_W-1:0] slot_key_x [CAPACITY];
   logic [tllm_pkg::KEY_W-1:0] slot_key_y [CAPACITY];
   bit                         occupied   [CAPACITY];
   int                         link_next  [CAPACITY];
   int                         link_prev  [CAPACITY];
   int                         entries    = 0;
   int                         head_slot  = 0;
   int                         tail_slot  = 0;

   list_reply_type pending_replies [$];

   int words_sent    = 0;
   int replies_seen  = 0;
   int mismatches    = 0;
   int full_refusals = 0;
   int miss_replies  = 0;
   int peak_entries  = 0;

   // idle control for both sides
   bit send_calm      = 1'b0;
   int send_calm_left = 0;
   bit recv_calm      = 1'b0;
   int recv_calm_left = 0;
   int recv_hold_left = 0;

   logic [tllm_pkg::KEY_W-1:0] key_pool [8];

   script_row_type script [SCRIPT_LEN] = '{
      // empty list: every read or removal misses
      '{tllm_pkg::OP_PEEK, 32'h0, 32'h0, 1'b1,
        '{tllm_pkg::STAT_MISS, 32'h0, 32'h0, 8'd0}},
      '{tllm_pkg::OP_POP, ONES_KEY, ONES_KEY, 1'b1,
        '{tllm_pkg::STAT_MISS, 32'h0, 32'h0, 8'd0}},
      '{tllm_pkg::OP_REMOVE, 32'h0, 32'h0, 1'b1,
        '{tllm_pkg::STAT_MISS, 32'h0, 32'h0, 8'd0}},
      // first entry becomes head and tail
      '{tllm_pkg::OP_APPEND, MIN_KEY, MAX_KEY, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd1}},
      '{tllm_pkg::OP_PEEK, MAX_KEY, MIN_KEY, 1'b1,
        '{tllm_pkg::STAT_DONE, MIN_KEY, MAX_KEY, 8'd1}},
      '{tllm_pkg::OP_APPEND, MAX_KEY, MIN_KEY, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd2}},
      // two equal pairs: removal must take the lower slot
      '{tllm_pkg::OP_APPEND, ONES_KEY, 32'h0, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd3}},
      '{tllm_pkg::OP_APPEND, ONES_KEY, 32'h0, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd4}},
      // only one half of the pair matches: a miss
      '{tllm_pkg::OP_REMOVE, MIN_KEY, MIN_KEY, 1'b1,
        '{tllm_pkg::STAT_MISS, 32'h0, 32'h0, 8'd4}},
      '{tllm_pkg::OP_REMOVE, MAX_KEY, MAX_KEY, 1'b1,
        '{tllm_pkg::STAT_MISS, 32'h0, 32'h0, 8'd4}},
      // middle entry out
      '{tllm_pkg::OP_REMOVE, ONES_KEY, 32'h0, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd3}},
      '{tllm_pkg::OP_PEEK, 32'h0, 32'h0, 1'b1,
        '{tllm_pkg::STAT_DONE, MIN_KEY, MAX_KEY, 8'd3}},
      // head entry out: head moves to its neighbor
      '{tllm_pkg::OP_REMOVE, MIN_KEY, MAX_KEY, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd2}},
      '{tllm_pkg::OP_PEEK, 32'h0, 32'h0, 1'b1,
        '{tllm_pkg::STAT_DONE, MAX_KEY, MIN_KEY, 8'd2}},
      // reuse of a freed low slot, then tail removal
      '{tllm_pkg::OP_APPEND, 32'd5, 32'd6, 1'b0, NO_REPLY},
      '{tllm_pkg::OP_REMOVE, 32'd5, 32'd6, 1'b0, NO_REPLY},
      '{tllm_pkg::OP_APPEND, 32'h1234_5678, 32'h9abc_def0, 1'b0, NO_REPLY},
      '{tllm_pkg::OP_POP, 32'h0, ONES_KEY, 1'b0, NO_REPLY},
      '{tllm_pkg::OP_PEEK, ONES_KEY, 32'h0, 1'b0, NO_REPLY},
      '{tllm_pkg::OP_POP, 32'h0, 32'h0, 1'b0, NO_REPLY},
      '{tllm_pkg::OP_PEEK, 32'h0, 32'h0, 1'b0, NO_REPLY},
      // last entry out: the list is empty again
      '{tllm_pkg::OP_REMOVE, 32'h1234_5678, 32'h9abc_def0, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd0}},
      '{tllm_pkg::OP_PEEK, 32'h0, 32'h0, 1'b1,
        '{tllm_pkg::STAT_MISS, 32'h0, 32'h0, 8'd0}},
      '{tllm_pkg::OP_APPEND, 32'd7, 32'd7, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd1}},
      '{tllm_pkg::OP_POP, 32'h0, 32'h0, 1'b1,
        '{tllm_pkg::STAT_DONE, 32'h0, 32'h0, 8'd0}}
   };

   // ---------------------------------------------------------------------
   // Clock, reset and run limit
   // ---------------------------------------------------------------------
   initial begin
      forever #6 clock = ~clock;
   end

   // far beyond the slowest legal run, long stalls included
   initial begin
      #30_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Take slot i out of the chain; rewrite only links of neighbors that exist.
   function automatic void drop_slot(int i);
      int  nx;
      int  pv;
      bit  was_head;
      bit  was_tail;
      nx       = link_next[i];
      pv       = link_prev[i];
      was_head = (i == head_slot);
      was_tail = (i == tail_slot);
      occupied[i] = 1'b0;
      if (entries > 0)
         entries--;
      // empty list: pointers go back to slot zero
      if (entries == 0) begin
         head_slot = 0;
         tail_slot = 0;
         return;
      end
      if (!was_head)
         link_next[pv] = nx;
      if (!was_tail)
         link_prev[nx] = pv;
      if (was_head)
         head_slot = nx;
      if (was_tail)
         tail_slot = pv;
   endfunction

   // Apply one request word to the shadow list and return the reply it must give.
   function automatic list_reply_type apply_list_op(tllm_pkg::op_type op,
                                                    logic [tllm_pkg::KEY_W-1:0] kx,
                                                    logic [tllm_pkg::KEY_W-1:0] ky);
      list_reply_type r;
      int             free_slot;
      r = NO_REPLY;
      case (op)
         tllm_pkg::OP_APPEND: begin
            free_slot = CAPACITY;
            if (entries < CAPACITY) begin
               for (int i = CAPACITY - 1; i >= 0; i--)
                  if (!occupied[i])
                     free_slot = i;
            end
            if (free_slot >= CAPACITY) begin
               r.status = tllm_pkg::STAT_FULL;
            end else begin
               slot_key_x[free_slot] = kx;
               slot_key_y[free_slot] = ky;
               occupied[free_slot]   = 1'b1;
               link_next[free_slot]  = free_slot;
               if (entries == 0) begin
                  head_slot            = free_slot;
                  link_prev[free_slot] = free_slot;
               end else begin
                  link_next[tail_slot] = free_slot;
                  link_prev[free_slot] = tail_slot;
               end
               tail_slot = free_slot;
               entries++;
            end
         end
         tllm_pkg::OP_REMOVE: begin
            r.status = tllm_pkg::STAT_MISS;
            for (int i = 0; i < CAPACITY; i++) begin
               if (r.status == tllm_pkg::STAT_MISS && occupied[i] &&
                   slot_key_x[i] == kx && slot_key_y[i] == ky) begin
                  drop_slot(i);
                  r.status = tllm_pkg::STAT_DONE;
               end
            end
         end
         tllm_pkg::OP_POP: begin
            if (entries == 0)
               r.status = tllm_pkg::STAT_MISS;
            else
               drop_slot(head_slot);
         end
         default: begin
            if (entries == 0) begin
               r.status = tllm_pkg::STAT_MISS;
            end else begin
               r.head_x = slot_key_x[head_slot];
               r.head_y = slot_key_y[head_slot];
            end
         end
      endcase
      r.entry_count = entries[tllm_pkg::ENTRY_W-1:0];
      if (r.status == tllm_pkg::STAT_FULL)
         full_refusals++;
      if (r.status == tllm_pkg::STAT_MISS)
         miss_replies++;
      if (entries > peak_entries)
         peak_entries = entries;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Mostly back to back or short gaps, now and then a long one; calm stretches
   // with no gaps at all.
   function automatic int word_gap();
      int r;
      if (send_calm_left == 0) begin
         send_calm      = ($urandom_range(0, 3) == 0);
         send_calm_left = $urandom_range(10, 60);
      end
      send_calm_left--;
      if (send_calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Present one word, hold it until taken, then log the reply it owes.
   task automatic send_word(input tllm_pkg::op_type op,
                            input logic [tllm_pkg::KEY_W-1:0] kx,
                            input logic [tllm_pkg::KEY_W-1:0] ky, input bit fixed,
                            input list_reply_type typed);
      list_reply_type predicted;
      int             gap;
      req_tdata  <= {{tllm_pkg::REQ_PAD_W{1'b0}}, ky, kx, op};
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      // taken at this edge: advance the shadow list
      predicted = apply_list_op(op, kx, ky);
      pending_replies.push_back(fixed ? typed : predicted);
      words_sent++;
      gap = word_gap();
      // with no gap, valid stays high and the next word goes out at this edge
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly keys from a small pool so pairs repeat and removals hit.
   function automatic logic [tllm_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 7)
         return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic random_word(input mix_type mix);
      int                         r;
      int                         idx;
      int                         bit_pos;
      tllm_pkg::op_type           op;
      logic [tllm_pkg::KEY_W-1:0] kx;
      logic [tllm_pkg::KEY_W-1:0] ky;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:
            op = (r < 60) ? tllm_pkg::OP_APPEND : (r < 78) ? tllm_pkg::OP_REMOVE :
                 (r < 88) ? tllm_pkg::OP_POP : tllm_pkg::OP_PEEK;
         MIX_EVEN:
            op = (r < 35) ? tllm_pkg::OP_APPEND : (r < 65) ? tllm_pkg::OP_REMOVE :
                 (r < 80) ? tllm_pkg::OP_POP : tllm_pkg::OP_PEEK;
         default:
            op = (r < 15) ? tllm_pkg::OP_APPEND : (r < 55) ? tllm_pkg::OP_REMOVE :
                 (r < 80) ? tllm_pkg::OP_POP : tllm_pkg::OP_PEEK;
      endcase
      kx = pick_key();
      ky = pick_key();
      // removal: usually a pair that is in the list, sometimes one bit off it
      if (op == tllm_pkg::OP_REMOVE && entries > 0 && $urandom_range(0, 3) != 0) begin
         idx = $urandom_range(0, CAPACITY - 1);
         while (!occupied[idx])
            idx = (idx + 1) % CAPACITY;
         kx = slot_key_x[idx];
         ky = slot_key_y[idx];
         if ($urandom_range(0, 4) == 0) begin
            bit_pos = $urandom_range(0, tllm_pkg::KEY_W - 1);
            if ($urandom_range(0, 1))
               ky[bit_pos] = ~ky[bit_pos];
            else
               kx[bit_pos] = ~kx[bit_pos];
         end
      end
      send_word(op, kx, ky, 1'b0, NO_REPLY);
   endtask

   task automatic run_mix(input mix_type mix, input int count);
      repeat (count) random_word(mix);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      key_pool[0] = 32'h0;
      key_pool[1] = MIN_KEY;
      key_pool[2] = MAX_KEY;
      key_pool[3] = ONES_KEY;
      for (int i = 4; i < 8; i++)
         key_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed script
      foreach (script[i])
         send_word(script[i].op, script[i].kx, script[i].ky, script[i].fixed,
                   script[i].reply);

      // random stretches: build up, churn, drain
      run_mix(MIX_GROW, 120);
      run_mix(MIX_EVEN, 100);
      run_mix(MIX_SHRINK, 150);

      // fill every slot, then knock on a full list
      while (entries < CAPACITY)
         send_word(tllm_pkg::OP_APPEND, pick_key(), pick_key(), 1'b0, NO_REPLY);
      repeat (4) send_word(tllm_pkg::OP_APPEND, $urandom, $urandom, 1'b0, NO_REPLY);
      send_word(tllm_pkg::OP_PEEK, $urandom, $urandom, 1'b0, NO_REPLY);

      run_mix(MIX_EVEN, 80);
      run_mix(MIX_SHRINK, 220);
      while (words_sent < SCRIPT_LEN + RANDOM_WORDS)
         run_mix(mix_type'($urandom_range(0, 2)), 40);

      req_tvalid <= 1'b0;

      // drain, then let any late stray word show up
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (CAPACITY + 20) @(posedge clock);

      $display("Sent %0d request words (%0d scripted); peak occupancy %0d of %0d,",
               words_sent, SCRIPT_LEN, peak_entries, CAPACITY);
      $display("  %0d appends refused as full, %0d miss replies, %0d replies checked",
               full_refusals, miss_replies, replies_seen);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Reply side: random back-pressure with calm stretches
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      int r;
      if (recv_calm_left == 0) begin
         recv_calm      = ($urandom_range(0, 3) == 0);
         recv_calm_left = $urandom_range(50, 400);
      end
      recv_calm_left--;
      if (recv_hold_left > 0) begin
         recv_hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_calm) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
         end else begin
            recv_hold_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 80);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Compare each taken reply word with the oldest one owed.
   always @(posedge clock) begin
      list_reply_type got;
      list_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = tllm_pkg::status_type'(rsp_tdata[tllm_pkg::STATUS_W-1:0]);
         got.head_x      = rsp_tdata[tllm_pkg::STATUS_W +: tllm_pkg::KEY_W];
         got.head_y      = rsp_tdata[tllm_pkg::STATUS_W + tllm_pkg::KEY_W +:
                                     tllm_pkg::KEY_W];
         got.entry_count = rsp_tdata[tllm_pkg::STATUS_W + 2 * tllm_pkg::KEY_W +:
                                     tllm_pkg::ENTRY_W];
         replies_seen++;
         if (pending_replies.size() == 0) begin
            $error("reply word with nothing owed: status %0d count %0d",
                   got.status, got.entry_count);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatches++;
            end
            if (got.head_x !== want.head_x) begin
               $error("head_x: expected %h, got %h", want.head_x, got.head_x);
               mismatches++;
            end
            if (got.head_y !== want.head_y) begin
               $error("head_y: expected %h, got %h", want.head_y, got.head_y);
               mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      got.entry_count);
               mismatches++;
            end
         end
      end
   end

endmodule
